FILE: rtl/core/pre_pkg.sv
package pre_pkg;

   // Default geometry of the slot table.
   localparam int SLOTS_DEF     = 16;
   localparam int AGE_BITS_DEF  = 32;
   localparam int PAGE_BITS_DEF = 27;

   // Configuration port geometry.
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGING_INIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POPCOUNT_INIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EVICT_ALLOWED  = 3'd4;

   // Policy codes; the unused code behaves as aging.
   localparam logic [1:0] POL_AGING    = 2'd0;
   localparam logic [1:0] POL_POPCOUNT = 2'd1;
   localparam logic [1:0] POL_FIFO     = 2'd2;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_MARK   = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_REFUSED   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_ALIGN,
      ST_PACK,
      ST_DONE
   } state_type;

   // Control handed to every cell of the slot ring.
   typedef struct packed {
      logic shift;   // rotate: each cell takes its upper neighbor
      logic pack;    // collapse: cells at or above a hole take their neighbor
   } cell_ctl_type;

   function automatic logic [6:0] popcount64(input logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(v[i]);
      end
      return n;
   endfunction

endpackage

FILE: rtl/core/pre_cell.sv
module pre_cell
   import pre_pkg::*;
#(
   parameter int AGE_BITS  = AGE_BITS_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [PAGE_BITS-1:0] next_page,
   input  logic [AGE_BITS-1:0]  next_age,
   input  logic                 next_valid,
   input  logic                 next_acc,
   input  logic                 hole_in,
   output logic [PAGE_BITS-1:0] page,
   output logic [AGE_BITS-1:0]  age,
   output logic                 valid,
   output logic                 acc,
   output logic                 hole_out
);

   logic [PAGE_BITS-1:0] page_ff;
   logic [AGE_BITS-1:0]  age_ff;
   logic                 valid_ff;
   logic                 acc_ff;
   logic                 take;

   // While packing, a cell moves down once any hole sits at or below it.
   assign hole_out = hole_in | ~valid_ff;
   assign take     = ctl.shift | (ctl.pack & hole_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= 1'b0;
      end else if (take) begin
         valid_ff <= next_valid;
         acc_ff   <= next_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         page_ff <= next_page;
         age_ff  <= next_age;
      end
   end

   assign page  = page_ff;
   assign age   = age_ff;
   assign valid = valid_ff;
   assign acc   = acc_ff;

endmodule

FILE: rtl/core/page_replacement_engine.sv
// Page replacement engine: a table of resident-page slots with a selectable
// victim policy (aging, fewest set age bits, or second-chance FIFO).
// Requests arrive on the req_ stream: tuser carries the mode (insert, remove,
// mark referenced, tick) and tdata the page number. Every request beat yields
// exactly one response beat on the rsp_ stream with the status, the slot, the
// eviction flag and page, and the number of resident pages afterwards.
// The slots live in a ring of cells that rotates one slot per cycle during a
// request's turns. Each request takes one rotation to scan the table and one
// to apply the change; the response is then loaded into an output register.
// A successful remove under the FIFO policy then turns the ring, if the hand
// is not at slot 0, until the hand's slot sits in the head cell, and compacts
// the ring, which puts the hand back at slot 0.
// One request is in flight at a time.
// The response sits in an output register; the next request is accepted
// while that beat still waits for rsp_tready. If the receiver stalls, a
// finished second request waits until the first beat is taken.
// Reset is synchronous and empties the table, puts the hand at slot 0 and
// loads the register defaults. Configuration writes are always accepted and
// must be issued only while no request is pending.
module page_replacement_engine
   import pre_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int AGE_BITS  = AGE_BITS_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   localparam int REQ_W    = ((PAGE_BITS + 7) / 8) * 8,
   localparam int SLOT_W   = $clog2(SLOTS),
   localparam int CNT_W    = $clog2(SLOTS + 1),
   localparam int RSP_RAW  = 2 + SLOT_W + 1 + PAGE_BITS + CNT_W,
   localparam int RSP_W    = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata: page_number
   input  logic [REQ_W-1:0]     req_tdata,
   // tuser: mode
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata: status, slot, evicted, evicted_page, occupied
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int PC_W = $clog2(AGE_BITS + 1);

   // Configuration registers.
   logic [1:0]       policy_ff;
   logic [CFG_W-1:0] aging_init_ff;
   logic [CFG_W-1:0] pop_init_ff;
   logic             bypass_ff;
   logic             evict_allowed_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff        <= POL_AGING;
         aging_init_ff    <= '0;
         pop_init_ff      <= '1;
         bypass_ff        <= 1'b0;
         evict_allowed_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POLICY:        policy_ff        <= csr_data[1:0];
            CSR_AGING_INIT:    aging_init_ff    <= csr_data;
            CSR_POPCOUNT_INIT: pop_init_ff      <= csr_data;
            CSR_BYPASS:        bypass_ff        <= csr_data[0];
            CSR_EVICT_ALLOWED: evict_allowed_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic pol_fifo;
   logic pol_pop;
   assign pol_fifo = (policy_ff == POL_FIFO);
   assign pol_pop  = (policy_ff == POL_POPCOUNT);

   // Control state.
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] hand_ff, hand_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   mode_type          mode_ff;
   logic [PAGE_BITS-1:0] pg_ff;
   cell_ctl_type      ctl;
   logic              accept;

   // Ring of cells; cell 0 is the head and holds slot pos_ff while turning.
   logic [PAGE_BITS-1:0] c_page  [SLOTS];
   logic [AGE_BITS-1:0]  c_age   [SLOTS];
   logic                 c_valid [SLOTS];
   logic                 c_acc   [SLOTS];
   logic                 c_hole  [SLOTS+1];

   logic [PAGE_BITS-1:0] mod_page;
   logic [AGE_BITS-1:0]  mod_age;
   logic                 mod_valid;
   logic                 mod_acc;

   assign c_hole[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [PAGE_BITS-1:0] n_page;
      logic [AGE_BITS-1:0]  n_age;
      logic                 n_valid;
      logic                 n_acc;
      if (i == SLOTS - 1) begin : g_tail
         // The tail takes the (possibly updated) head, or an empty slot
         // while packing.
         assign n_page  = mod_page;
         assign n_age   = mod_age;
         assign n_valid = mod_valid & ~ctl.pack;
         assign n_acc   = mod_acc & ~ctl.pack;
      end else begin : g_body
         assign n_page  = c_page[i+1];
         assign n_age   = c_age[i+1];
         assign n_valid = c_valid[i+1];
         assign n_acc   = c_acc[i+1];
      end
      pre_cell #(
         .AGE_BITS  (AGE_BITS),
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .next_page  (n_page),
         .next_age   (n_age),
         .next_valid (n_valid),
         .next_acc   (n_acc),
         .hole_in    (c_hole[i]),
         .page       (c_page[i]),
         .age        (c_age[i]),
         .valid      (c_valid[i]),
         .acc        (c_acc[i]),
         .hole_out   (c_hole[i+1])
      );
   end

   // Scan results, gathered as the head passes during the first rotation.
   logic              found_ff, free_ff, ca_ff, cb_ff;
   logic [SLOT_W-1:0] found_idx_ff, free_idx_ff, ca_idx_ff, cb_idx_ff, best_idx_ff;
   logic [AGE_BITS-1:0] best_age_ff;
   logic [PC_W-1:0]   best_pc_ff;
   logic [PAGE_BITS-1:0] evp_ff;
   logic [PC_W-1:0]   head_pc;
   logic              better;

   assign head_pc = PC_W'(popcount64(64'(c_age[0])));
   // Ties go to the later slot under both least-age policies.
   assign better  = pol_pop ? ((head_pc < best_pc_ff) ||
                               ((head_pc == best_pc_ff) && (c_age[0] <= best_age_ff)))
                            : (c_age[0] <= best_age_ff);

   always_ff @(posedge clock) begin
      if (reset || accept) begin
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         ca_ff    <= 1'b0;
         cb_ff    <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (!found_ff && c_valid[0] && (c_page[0] == pg_ff)) begin
            found_ff     <= 1'b1;
            found_idx_ff <= pos_ff;
         end
         if (!free_ff && !c_valid[0]) begin
            free_ff     <= 1'b1;
            free_idx_ff <= pos_ff;
         end
         if (!ca_ff && !c_acc[0] && (pos_ff >= hand_ff)) begin
            ca_ff     <= 1'b1;
            ca_idx_ff <= pos_ff;
         end
         if (!cb_ff && !c_acc[0] && (pos_ff < hand_ff)) begin
            cb_ff     <= 1'b1;
            cb_idx_ff <= pos_ff;
         end
         if ((pos_ff == '0) || better) begin
            best_idx_ff <= pos_ff;
            best_age_ff <= c_age[0];
            best_pc_ff  <= head_pc;
         end
      end
   end

   // Decisions taken from the scan.
   logic              full, ins_ok, evict, allset;
   logic [SLOT_W-1:0] victim, target, victim_next;
   logic [AGE_BITS-1:0] init_age;
   logic [63:0]       aging_ext, pop_ext;
   logic [SLOT_W:0]   dist_head, dist_victim;

   assign full     = ~free_ff;
   assign ins_ok   = ~bypass_ff & (~full | evict_allowed_ff);
   assign evict    = ins_ok & full;
   assign allset   = ~ca_ff & ~cb_ff;
   assign victim   = pol_fifo ? (ca_ff ? ca_idx_ff : (cb_ff ? cb_idx_ff : hand_ff))
                              : best_idx_ff;
   assign target   = full ? victim : free_idx_ff;
   assign victim_next = (victim == SLOT_W'(SLOTS - 1)) ? '0 : victim + 1'b1;
   assign aging_ext = 64'(aging_init_ff);
   assign pop_ext   = 64'(pop_init_ff);
   assign init_age  = pol_fifo ? '0 :
                      pol_pop  ? pop_ext[AGE_BITS-1:0] : aging_ext[AGE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_type'(req_tuser);
         pg_ff   <= req_tdata[PAGE_BITS-1:0];
      end
      if ((state_ff == ST_APPLY) && (pos_ff == target)) begin
         evp_ff <= c_page[0];
      end
   end

   // Distance from the hand, around the ring.
   assign dist_head   = (pos_ff >= hand_ff)
                      ? ({1'b0, pos_ff} - {1'b0, hand_ff})
                      : ({1'b0, pos_ff} + (SLOT_W+1)'(SLOTS) - {1'b0, hand_ff});
   assign dist_victim = (victim >= hand_ff)
                      ? ({1'b0, victim} - {1'b0, hand_ff})
                      : ({1'b0, victim} + (SLOT_W+1)'(SLOTS) - {1'b0, hand_ff});

   // Update of the head slot on its way to the tail during the apply turn.
   always_comb begin
      mod_page  = c_page[0];
      mod_age   = c_age[0];
      mod_valid = c_valid[0];
      mod_acc   = c_acc[0];
      if (state_ff == ST_APPLY) begin
         unique case (mode_ff)
            MODE_INSERT: begin
               if (ins_ok && (pos_ff == target)) begin
                  mod_page  = pg_ff;
                  mod_valid = 1'b1;
                  mod_acc   = 1'b0;
                  mod_age   = init_age;
               end else if (evict && pol_fifo &&
                            (allset || (dist_head < dist_victim))) begin
                  mod_acc = 1'b0;
               end
            end
            MODE_REMOVE: begin
               if (found_ff && (pos_ff == found_idx_ff)) begin
                  mod_page  = '0;
                  mod_age   = '0;
                  mod_valid = 1'b0;
                  mod_acc   = 1'b0;
               end
            end
            MODE_MARK: begin
               if (found_ff && (pos_ff == found_idx_ff)) begin
                  mod_acc = 1'b1;
               end
            end
            MODE_TICK: begin
               if (!pol_fifo && c_valid[0]) begin
                  mod_age = {c_acc[0], c_age[0][AGE_BITS-1:1]};
                  mod_acc = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Response fields.
   status_type        rsp_status;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_evicted;
   logic [PAGE_BITS-1:0] rsp_evp;

   always_comb begin
      rsp_status  = STATUS_DONE;
      rsp_slot    = '0;
      rsp_evicted = 1'b0;
      unique case (mode_ff)
         MODE_INSERT: begin
            if (ins_ok) begin
               rsp_slot    = target;
               rsp_evicted = evict;
            end else begin
               rsp_status = STATUS_REFUSED;
            end
         end
         MODE_REMOVE, MODE_MARK: begin
            if (found_ff) begin
               rsp_slot = found_idx_ff;
            end else begin
               rsp_status = STATUS_NOT_FOUND;
            end
         end
         default: ;
      endcase
      rsp_evp = rsp_evicted ? evp_ff : '0;
   end

   logic [SLOT_W-1:0] pos_step;
   logic              pos_last;
   assign pos_last = (pos_ff == SLOT_W'(SLOTS - 1));
   assign pos_step = pos_last ? '0 : pos_ff + 1'b1;
   assign accept   = req_tvalid & req_tready;

   // Sequencer: scan turn, apply turn, optional align and pack, response.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      hand_in      = hand_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ctl          = '{shift: 1'b0, pack: 1'b0};
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SCAN;
               pos_in   = '0;
            end
         end
         ST_SCAN: begin
            ctl.shift = 1'b1;
            pos_in    = pos_step;
            if (pos_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            ctl.shift = 1'b1;
            pos_in    = pos_step;
            if (pos_last) begin
               state_in = ST_DONE;
               if ((mode_ff == MODE_INSERT) && ins_ok) begin
                  if (!full) begin
                     count_in = count_ff + 1'b1;
                  end else if (pol_fifo) begin
                     hand_in = victim_next;
                  end
               end
               if ((mode_ff == MODE_REMOVE) && found_ff) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
                  if (pol_fifo) begin
                     state_in = (hand_ff != '0) ? ST_ALIGN : ST_PACK;
                  end
               end
            end
         end
         ST_ALIGN: begin
            // Turn the ring until the hand's slot sits in the head cell.
            ctl.shift = 1'b1;
            pos_in    = pos_step;
            if ((CNT_W'(pos_ff) + 1'b1) == CNT_W'(hand_ff)) begin
               state_in = ST_PACK;
               pos_in   = '0;
            end
         end
         ST_PACK: begin
            ctl.pack = 1'b1;
            pos_in   = pos_step;
            if (pos_last) begin
               state_in = ST_DONE;
               hand_in  = '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({count_ff, rsp_evp, rsp_evicted, rsp_slot,
                                      rsp_status});
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         hand_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         hand_ff      <= hand_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks.
   logic [SLOTS-1:0] valid_vec;
   for (genvar i = 0; i < SLOTS; i++) begin : g_vvec
      assign valid_vec[i] = c_valid[i];
   end

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == 32'(count_ff)))
      else $error("resident count differs from valid slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= SLOTS)
      else $error("resident count above slot count");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_hand_zero_after_pack: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PACK) && pos_last) |=> (hand_ff == '0))
      else $error("hand not reset after compaction");

endmodule
